[src/vqncs_pkg.sv]
// Shared types and constants for the vector-quantizer nearest-codeword search.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package vqncs_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CODE_IDX_W   = 6;
    localparam int DIM_IDX_W    = 4;
    localparam int DIST_W       = 38;
    localparam int IDX_OUT_W    = 6;
    localparam int DIMS_REG_W   = 5;
    localparam int CODES_REG_W  = 7;
    localparam int CFG_ADDR_W   = 1;
    localparam int CFG_DATA_W   = 7;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 48;

    localparam logic [DIMS_REG_W-1:0]  DIMS_RESET  = 5'd16;
    localparam logic [CODES_REG_W-1:0] CODES_RESET = 7'd64;

    localparam logic REQ_CODEBOOK = 1'b0;
    localparam logic REQ_QUERY    = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIMS_IN_USE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CODES_IN_USE = 1'b1;

    typedef struct packed {
        logic wr_cb;
        logic wr_qb;
        logic rd_en;
        logic first_dim;
        logic last_dim;
        logic first_code;
        logic last_code;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

[src/vq_nearest_codeword_search_unit.sv]
// Search: once the last query word is accepted, the multiply-accumulate takes one
// codebook element per cycle from the single read port of the codebook memory.
// Throughput: codebook and non-last query words are taken one per cycle while
// idle; s_axis_tready is low from the search until the result word is loaded.
// Reset: synchronous, active low; the registers return to 16 dimensions and
// 64 codewords, while the codebook and query buffer keep their contents.
`timescale 1ns / 1ps

module vq_nearest_codeword_search_unit #(
    parameter int MAX_DIMS  = 16,
    parameter int MAX_CODES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [vqncs_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [vqncs_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // code_index[5:0], dim_index[9:6], sample_value[25:10], zero fill above.
    input  logic [vqncs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // req_type.
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // nearest_index[5:0], min_distance[43:6], zero fill above.
    output logic [vqncs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
    import vqncs_pkg::*;

    localparam int DIM_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CODE_AW = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;

    t_dp_cmd               cmd;
    t_dp_status            status;
    logic [CODE_AW-1:0]    rd_code;
    logic [DIM_AW-1:0]     rd_dim;
    logic [IDX_OUT_W-1:0]  nearest_index;
    logic [DIST_W-1:0]     min_distance;

    vqncs_ctrl #(
        .MAX_DIMS  (MAX_DIMS),
        .MAX_CODES (MAX_CODES),
        .DIM_AW    (DIM_AW),
        .CODE_AW   (CODE_AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_type   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .o_rd_code   (rd_code),
        .o_rd_dim    (rd_dim),
        .i_status    (status)
    );

    vqncs_dp #(
        .MAX_DIMS  (MAX_DIMS),
        .MAX_CODES (MAX_CODES),
        .DIM_AW    (DIM_AW),
        .CODE_AW   (CODE_AW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_code       (rd_code),
        .i_rd_dim        (rd_dim),
        .i_code_index    (s_axis_tdata[CODE_IDX_W-1:0]),
        .i_dim_index     (s_axis_tdata[CODE_IDX_W+DIM_IDX_W-1:CODE_IDX_W]),
        .i_sample_value  (s_axis_tdata[CODE_IDX_W+DIM_IDX_W+SAMPLE_W-1:CODE_IDX_W+DIM_IDX_W]),
        .o_status        (status),
        .o_nearest_index (nearest_index),
        .o_min_distance  (min_distance)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - DIST_W - IDX_OUT_W){1'b0}},
                           min_distance, nearest_index};

endmodule

[src/vqncs_ctrl.sv]
// Controller for the nearest-codeword search: handshakes, configuration
// registers and the row/dimension sequencer. Depends on vqncs_pkg.
`timescale 1ns / 1ps

module vqncs_ctrl #(
    parameter int MAX_DIMS  = 16,
    parameter int MAX_CODES = 64,
    parameter int DIM_AW    = 4,
    parameter int CODE_AW   = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [vqncs_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [vqncs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    input  logic                         i_in_type,
    input  logic                         i_in_last,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output vqncs_pkg::t_dp_cmd           o_cmd,
    output logic [CODE_AW-1:0]           o_rd_code,
    output logic [DIM_AW-1:0]            o_rd_dim,
    input  vqncs_pkg::t_dp_status        i_status
);
    import vqncs_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [DIMS_REG_W-1:0]  r_dims_cfg;
    logic [CODES_REG_W-1:0] r_codes_cfg;
    logic [DIM_AW-1:0]      r_dim_cnt, n_dim_cnt;
    logic [CODE_AW-1:0]     r_code_cnt, n_code_cnt;
    logic [DIM_AW-1:0]      r_last_dim, n_last_dim;
    logic [CODE_AW-1:0]     r_last_code, n_last_code;
    logic                   r_out_valid, n_out_valid;
    logic                   in_accept;
    logic                   start;
    logic                   at_last_dim;
    logic                   at_last_code;
    logic                   load_out;
    logic [31:0]            dims_lim32;
    logic [31:0]            codes_lim32;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign in_accept    = i_in_valid && o_in_ready;
    assign start        = in_accept && (i_in_type == REQ_QUERY) && i_in_last;
    assign at_last_dim  = (r_dim_cnt == r_last_dim);
    assign at_last_code = (r_code_cnt == r_last_code);
    assign load_out     = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign o_out_valid  = r_out_valid;
    assign o_rd_code    = r_code_cnt;
    assign o_rd_dim     = r_dim_cnt;

    always_comb begin
        if (r_dims_cfg == '0) begin
            dims_lim32 = 32'd0;
        end else if (32'(r_dims_cfg) > 32'(MAX_DIMS)) begin
            dims_lim32 = 32'(MAX_DIMS - 1);
        end else begin
            dims_lim32 = 32'(r_dims_cfg) - 32'd1;
        end
        if (r_codes_cfg == '0) begin
            codes_lim32 = 32'd0;
        end else if (32'(r_codes_cfg) > 32'(MAX_CODES)) begin
            codes_lim32 = 32'(MAX_CODES - 1);
        end else begin
            codes_lim32 = 32'(r_codes_cfg) - 32'd1;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_cb      = in_accept && (i_in_type == REQ_CODEBOOK);
        o_cmd.wr_qb      = in_accept && (i_in_type == REQ_QUERY);
        o_cmd.rd_en      = (r_state == ST_SEARCH);
        o_cmd.first_dim  = (r_dim_cnt == '0);
        o_cmd.last_dim   = at_last_dim;
        o_cmd.first_code = (r_code_cnt == '0);
        o_cmd.last_code  = at_last_code;
        o_cmd.load_out   = load_out;
    end

    always_comb begin
        n_state     = r_state;
        n_dim_cnt   = r_dim_cnt;
        n_code_cnt  = r_code_cnt;
        n_last_dim  = r_last_dim;
        n_last_code = r_last_code;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state     = ST_SEARCH;
                    n_dim_cnt   = '0;
                    n_code_cnt  = '0;
                    n_last_dim  = dims_lim32[DIM_AW-1:0];
                    n_last_code = codes_lim32[CODE_AW-1:0];
                end
            end
            ST_SEARCH: begin
                if (at_last_dim) begin
                    n_dim_cnt  = '0;
                    n_code_cnt = r_code_cnt + 1'b1;
                    if (at_last_code) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_dim_cnt = r_dim_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (i_status.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dims_cfg  <= DIMS_RESET;
            r_codes_cfg <= CODES_RESET;
            r_dim_cnt   <= '0;
            r_code_cnt  <= '0;
            r_last_dim  <= '0;
            r_last_code <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dim_cnt   <= n_dim_cnt;
            r_code_cnt  <= n_code_cnt;
            r_last_dim  <= n_last_dim;
            r_last_code <= n_last_code;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_DIMS_IN_USE:  r_dims_cfg  <= i_cfg_wdata[DIMS_REG_W-1:0];
                    CFG_CODES_IN_USE: r_codes_cfg <= i_cfg_wdata[CODES_REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[src/vqncs_dp.sv]
// Datapath for the nearest-codeword search: codebook memory, query buffer,
// difference, square, accumulate and minimum stages. Depends on vqncs_pkg.
`timescale 1ns / 1ps

module vqncs_dp #(
    parameter int MAX_DIMS  = 16,
    parameter int MAX_CODES = 64,
    parameter int DIM_AW    = 4,
    parameter int CODE_AW   = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vqncs_pkg::t_dp_cmd                  i_cmd,
    input  logic [CODE_AW-1:0]                  i_rd_code,
    input  logic [DIM_AW-1:0]                   i_rd_dim,
    input  logic [vqncs_pkg::CODE_IDX_W-1:0]    i_code_index,
    input  logic [vqncs_pkg::DIM_IDX_W-1:0]     i_dim_index,
    input  logic signed [vqncs_pkg::SAMPLE_W-1:0] i_sample_value,
    output vqncs_pkg::t_dp_status               o_status,
    output logic [vqncs_pkg::IDX_OUT_W-1:0]     o_nearest_index,
    output logic [vqncs_pkg::DIST_W-1:0]        o_min_distance
);
    import vqncs_pkg::*;

    localparam int CB_DEPTH = MAX_CODES * MAX_DIMS;
    localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;

    logic signed [SAMPLE_W-1:0] r_cb_mem [CB_DEPTH];
    logic signed [SAMPLE_W-1:0] r_qb_mem [MAX_DIMS];

    logic [31:0]          wr_addr32;
    logic [31:0]          rd_addr32;
    logic [31:0]          qb_widx32;
    logic [CB_AW-1:0]     wr_addr;
    logic [CB_AW-1:0]     rd_addr;
    logic [DIM_AW-1:0]    qb_widx;
    logic                 cb_wr_ok;
    logic                 qb_wr_ok;

    logic signed [SAMPLE_W-1:0] r_cb_rd;
    logic signed [SAMPLE_W-1:0] r_qb_rd;
    logic                 r_v1, r_fd1, r_ld1, r_fc1, r_lc1;
    logic [CODE_AW-1:0]   r_code1;

    logic signed [SAMPLE_W:0] diff_c;
    logic signed [SAMPLE_W:0] r_diff;
    logic                 r_v2, r_fd2, r_ld2, r_fc2, r_lc2;
    logic [CODE_AW-1:0]   r_code2;

    logic signed [2*SAMPLE_W+1:0] sq_c;
    logic [2*SAMPLE_W-1:0] r_sq;
    logic                 r_v3, r_fd3, r_ld3, r_fc3, r_lc3;
    logic [CODE_AW-1:0]   r_code3;

    logic [DIST_W-1:0]    r_acc, n_acc;
    logic                 r_acc_done, r_acc_fc, r_acc_lc;
    logic [CODE_AW-1:0]   r_acc_code;

    logic [DIST_W-1:0]    r_best_dist;
    logic [CODE_AW-1:0]   r_best_idx;
    logic                 r_done;
    logic [31:0]          best_idx32;

    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [DIST_W-1:0]    r_out_dist;

    assign wr_addr32 = 32'(i_code_index) * 32'(MAX_DIMS) + 32'(i_dim_index);
    assign rd_addr32 = 32'(i_rd_code) * 32'(MAX_DIMS) + 32'(i_rd_dim);
    assign qb_widx32 = 32'(i_dim_index);
    assign wr_addr   = wr_addr32[CB_AW-1:0];
    assign rd_addr   = rd_addr32[CB_AW-1:0];
    assign qb_widx   = qb_widx32[DIM_AW-1:0];
    assign cb_wr_ok  = (32'(i_code_index) < 32'(MAX_CODES)) &&
                       (32'(i_dim_index) < 32'(MAX_DIMS));
    assign qb_wr_ok  = (32'(i_dim_index) < 32'(MAX_DIMS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cb && cb_wr_ok) begin
            r_cb_mem[wr_addr] <= i_sample_value;
        end
        if (i_cmd.rd_en) begin
            r_cb_rd <= r_cb_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_qb && qb_wr_ok) begin
            r_qb_mem[qb_widx] <= i_sample_value;
        end
        if (i_cmd.rd_en) begin
            r_qb_rd <= r_qb_mem[i_rd_dim];
        end
    end

    assign diff_c = {r_cb_rd[SAMPLE_W-1], r_cb_rd} - {r_qb_rd[SAMPLE_W-1], r_qb_rd};
    assign sq_c   = r_diff * r_diff;
    assign n_acc  = (r_fd3 ? '0 : r_acc) + {{(DIST_W - 2*SAMPLE_W){1'b0}}, r_sq};

    always_ff @(posedge i_clk) begin
        r_code1 <= i_rd_code;
        r_fd1   <= i_cmd.first_dim;
        r_ld1   <= i_cmd.last_dim;
        r_fc1   <= i_cmd.first_code;
        r_lc1   <= i_cmd.last_code;

        r_diff  <= diff_c;
        r_code2 <= r_code1;
        r_fd2   <= r_fd1;
        r_ld2   <= r_ld1;
        r_fc2   <= r_fc1;
        r_lc2   <= r_lc1;

        r_sq    <= sq_c[2*SAMPLE_W-1:0];
        r_code3 <= r_code2;
        r_fd3   <= r_fd2;
        r_ld3   <= r_ld2;
        r_fc3   <= r_fc2;
        r_lc3   <= r_lc2;

        if (r_v3) begin
            r_acc <= n_acc;
        end
        r_acc_code <= r_code3;
        r_acc_fc   <= r_fc3;
        r_acc_lc   <= r_lc3;

        if (r_acc_done && (r_acc_fc || (r_acc < r_best_dist))) begin
            r_best_dist <= r_acc;
            r_best_idx  <= r_acc_code;
        end

        if (i_cmd.load_out) begin
            r_out_idx  <= best_idx32[IDX_OUT_W-1:0];
            r_out_dist <= r_best_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_acc_done <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_v1       <= i_cmd.rd_en;
            r_v2       <= r_v1;
            r_v3       <= r_v2;
            r_acc_done <= r_v3 && r_ld3;
            r_done     <= r_acc_done && r_acc_lc;
        end
    end

    assign best_idx32      = 32'(r_best_idx);
    assign o_status.done   = r_done;
    assign o_nearest_index = r_out_idx;
    assign o_min_distance  = r_out_dist;

endmodule
